[sv/ckmc_pkg.sv]
// Shared constants, types and helpers for the color key mask and centroid block.
package ckmc_pkg;

    localparam int MaxRows = 4096;
    localparam int MaxCols = 4096;

    localparam int PIX_W      = 8;
    localparam int POS_W      = 12;
    localparam int CNT_W      = 25;
    localparam int SUM_W      = 37;
    localparam int SIZE_W     = 13;
    localparam int THR_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 40;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int DIV_STEPS = POS_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [PIX_W-1:0]  MASK_ON  = 8'hFF;
    localparam logic [PIX_W-1:0]  MASK_OFF = 8'h00;

    localparam logic [PIX_W-1:0]  RST_TARGET_CH0 = 8'd255;
    localparam logic [PIX_W-1:0]  RST_TARGET_CH1 = 8'd0;
    localparam logic [PIX_W-1:0]  RST_TARGET_CH2 = 8'd0;
    localparam logic [THR_W-1:0]  RST_THRESHOLD  = 10'd200;
    localparam logic [SIZE_W-1:0] RST_ROWS       = 13'd480;
    localparam logic [SIZE_W-1:0] RST_COLS       = 13'd640;

    localparam logic KIND_MASK     = 1'b0;
    localparam logic KIND_CENTROID = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_CH0 = 3'd0,
        CFG_TARGET_CH1 = 3'd1,
        CFG_TARGET_CH2 = 3'd2,
        CFG_THRESHOLD  = 3'd3,
        CFG_ROWS       = 3'd4,
        CFG_COLS       = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BK_MASK,
        BK_DIV,
        BK_CENT
    } t_bk_state;

    // one classified pixel on its way to the back end
    typedef struct packed {
        logic             frame_end;
        logic             marked;
        logic [SUM_W-1:0] row_sum;
        logic [SUM_W-1:0] col_sum;
        logic [CNT_W-1:0] count;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] max);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > max)
            r = max;
        else
            r = v;
        return r;
    endfunction

endpackage

[sv/ckmc_front.sv]
// Front end: config registers, pixel classification, raster position and accumulators.
module ckmc_front import ckmc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_pix_valid,
    input  logic [S_DATA_W-1:0]   i_pix,        // ch0 [7:0], ch1 [15:8], ch2 [23:16]
    output logic                  o_pix_ready,
    input  t_q_stat               i_q_stat,
    output logic                  o_q_push,
    output t_job                  o_q_job
);

    logic [PIX_W-1:0]  r_target0, r_target1, r_target2;
    logic [THR_W-1:0]  r_thr;
    logic [SIZE_W-1:0] r_rows, r_cols;

    logic [POS_W-1:0]  r_row, r_col;
    logic [CNT_W-1:0]  r_count;
    logic [SUM_W-1:0]  r_row_sum, r_col_sum;

    logic [PIX_W-1:0]  p0, p1, p2, d0, d1, d2;
    logic [THR_W-1:0]  l1_dist;
    logic              marked, row_end, frame_end, accept;
    logic [SIZE_W-1:0] rows_eff, cols_eff;
    logic [CNT_W-1:0]  n_count;
    logic [SUM_W-1:0]  n_row_sum, n_col_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target0 <= RST_TARGET_CH0;
            r_target1 <= RST_TARGET_CH1;
            r_target2 <= RST_TARGET_CH2;
            r_thr     <= RST_THRESHOLD;
            r_rows    <= RST_ROWS;
            r_cols    <= RST_COLS;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TARGET_CH0: r_target0 <= i_cfg_data[PIX_W-1:0];
                CFG_TARGET_CH1: r_target1 <= i_cfg_data[PIX_W-1:0];
                CFG_TARGET_CH2: r_target2 <= i_cfg_data[PIX_W-1:0];
                CFG_THRESHOLD:  r_thr     <= i_cfg_data[THR_W-1:0];
                CFG_ROWS:       r_rows    <= i_cfg_data[SIZE_W-1:0];
                CFG_COLS:       r_cols    <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        p0 = i_pix[PIX_W-1:0];
        p1 = i_pix[2*PIX_W-1:PIX_W];
        p2 = i_pix[3*PIX_W-1:2*PIX_W];
        d0 = (p0 > r_target0) ? p0 - r_target0 : r_target0 - p0;
        d1 = (p1 > r_target1) ? p1 - r_target1 : r_target1 - p1;
        d2 = (p2 > r_target2) ? p2 - r_target2 : r_target2 - p2;
        l1_dist = THR_W'(d0) + THR_W'(d1) + THR_W'(d2);
        marked = (l1_dist >= r_thr);

        rows_eff  = clamp_size(r_rows, SIZE_W'(MaxRows));
        cols_eff  = clamp_size(r_cols, SIZE_W'(MaxCols));
        row_end   = (SIZE_W'(r_col) + SIZE_W'(1)) >= cols_eff;
        frame_end = row_end && ((SIZE_W'(r_row) + SIZE_W'(1)) >= rows_eff);

        n_count   = marked ? r_count + CNT_W'(1) : r_count;
        n_row_sum = marked ? r_row_sum + SUM_W'(r_row) : r_row_sum;
        n_col_sum = marked ? r_col_sum + SUM_W'(r_col) : r_col_sum;

        o_pix_ready = !i_q_stat.full;
        accept      = i_pix_valid && o_pix_ready;
        o_q_push    = accept;

        o_q_job.frame_end = frame_end;
        o_q_job.marked    = marked;
        o_q_job.row_sum   = n_row_sum;
        o_q_job.col_sum   = n_col_sum;
        o_q_job.count     = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_count   <= '0;
            r_row_sum <= '0;
            r_col_sum <= '0;
        end else if (accept) begin
            if (frame_end) begin
                r_row     <= '0;
                r_col     <= '0;
                r_count   <= '0;
                r_row_sum <= '0;
                r_col_sum <= '0;
            end else begin
                r_count   <= n_count;
                r_row_sum <= n_row_sum;
                r_col_sum <= n_col_sum;
                if (row_end) begin
                    r_col <= '0;
                    r_row <= r_row + POS_W'(1);
                end else begin
                    r_col <= r_col + POS_W'(1);
                end
            end
        end
    end

endmodule

[sv/ckmc_fifo.sv]
// Short job queue between the front and back ends.
module ckmc_fifo import ckmc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wr <= r_wr + QPTR_W'(1);
            if (i_pop)
                r_rd <= r_rd + QPTR_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

[sv/ckmc_back.sv]
// Back end: emits mask beats, runs the centroid divider and holds the output register.
module ckmc_back import ckmc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_job                i_job,
    input  t_q_stat             i_q_stat,
    output logic                o_pop,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,
    output logic                o_m_tuser,
    output logic                o_m_tlast
);

    t_bk_state            r_state, n_state;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_kind, n_out_kind;
    logic [PIX_W-1:0]     r_out_mask, n_out_mask;
    logic [POS_W-1:0]     r_out_crow, n_out_crow;
    logic [POS_W-1:0]     r_out_ccol, n_out_ccol;
    logic                 r_out_none, n_out_none;
    logic                 r_out_last, n_out_last;

    logic [SUM_W-1:0]     r_rem_row, n_rem_row;
    logic [SUM_W-1:0]     r_rem_col, n_rem_col;
    logic [SUM_W-1:0]     r_dsh, n_dsh;
    logic [POS_W-1:0]     r_q_row, n_q_row;
    logic [POS_W-1:0]     r_q_col, n_q_col;
    logic [DIV_CNT_W-1:0] r_step, n_step;
    logic                 r_none, n_none;

    logic                 out_free, ge_row, ge_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_MASK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_mask <= n_out_mask;
        r_out_crow <= n_out_crow;
        r_out_ccol <= n_out_ccol;
        r_out_none <= n_out_none;
        r_out_last <= n_out_last;
        r_rem_row  <= n_rem_row;
        r_rem_col  <= n_rem_col;
        r_dsh      <= n_dsh;
        r_q_row    <= n_q_row;
        r_q_col    <= n_q_col;
        r_step     <= n_step;
        r_none     <= n_none;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_mask  = r_out_mask;
        n_out_crow  = r_out_crow;
        n_out_ccol  = r_out_ccol;
        n_out_none  = r_out_none;
        n_out_last  = r_out_last;
        n_rem_row   = r_rem_row;
        n_rem_col   = r_rem_col;
        n_dsh       = r_dsh;
        n_q_row     = r_q_row;
        n_q_col     = r_q_col;
        n_step      = r_step;
        n_none      = r_none;
        o_pop       = 1'b0;

        out_free = !r_out_valid || i_m_tready;
        ge_row   = (r_rem_row >= r_dsh);
        ge_col   = (r_rem_col >= r_dsh);

        if (r_out_valid && i_m_tready)
            n_out_valid = 1'b0;

        case (r_state)
            BK_MASK: begin
                if (!i_q_stat.empty && out_free) begin
                    o_pop       = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_MASK;
                    n_out_mask  = i_job.marked ? MASK_ON : MASK_OFF;
                    n_out_crow  = '0;
                    n_out_ccol  = '0;
                    n_out_none  = 1'b0;
                    n_out_last  = !i_job.frame_end;
                    if (i_job.frame_end) begin
                        // quotient is a mean of 12-bit positions, so 12 bits suffice
                        n_rem_row = i_job.row_sum;
                        n_rem_col = i_job.col_sum;
                        n_dsh     = SUM_W'(i_job.count) << (DIV_STEPS - 1);
                        n_none    = (i_job.count == '0);
                        n_step    = DIV_CNT_W'(DIV_STEPS - 1);
                        n_state   = BK_DIV;
                    end
                end
            end
            BK_DIV: begin
                if (ge_row)
                    n_rem_row = r_rem_row - r_dsh;
                if (ge_col)
                    n_rem_col = r_rem_col - r_dsh;
                n_q_row = {r_q_row[POS_W-2:0], ge_row};
                n_q_col = {r_q_col[POS_W-2:0], ge_col};
                n_dsh   = r_dsh >> 1;
                if (r_step == '0)
                    n_state = BK_CENT;
                else
                    n_step = r_step - DIV_CNT_W'(1);
            end
            BK_CENT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_CENTROID;
                    n_out_mask  = MASK_OFF;
                    n_out_crow  = r_none ? '0 : r_q_row;
                    n_out_ccol  = r_none ? '0 : r_q_col;
                    n_out_none  = r_none;
                    n_out_last  = 1'b1;
                    n_state     = BK_MASK;
                end
            end
            default: n_state = BK_MASK;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {7'b0, r_out_none, r_out_ccol, r_out_crow, r_out_mask};

endmodule

[sv/color_key_mask_centroid.sv]
// Top level of the color key mask and centroid block.
// Pixels arrive in raster order, one per beat, and each gives one mask beat (0 near the
// target color, 255 otherwise) in the same order. The last pixel of a frame gives a
// second beat, tuser high, with the truncated mean row and column of the 255 pixels,
// or zeros and no_pixels set when there were none; that beat carries tlast. The front
// end takes one pixel per cycle while the four-entry job queue has room; the back end
// emits one mask beat per cycle while jobs are queued and the output is accepted, and a
// frame end costs it the mask beat, 12 steps of the shared restoring divider that forms
// both means, and the centroid beat. No queue entry is popped meanwhile, so the pixels
// after a frame end wait once the queue is full. No clearing pass after reset. Config
// writes are taken at any time and must only be made while the block is idle.
module color_key_mask_centroid import ckmc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_DATA_W-1:0]   i_s_tdata,   // pixel_ch0, pixel_ch1, pixel_ch2
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_DATA_W-1:0]   o_m_tdata,   // mask_value, centroid_row, centroid_col,
                                               // no_pixels, zero pad
    output logic                  o_m_tuser,   // result_kind
    output logic                  o_m_tlast    // last_result
);

    t_job    q_in_job, q_head;
    t_q_stat q_stat;
    logic    q_push, q_pop;

    assign o_cfg_ready = 1'b1;

    ckmc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix_valid (i_s_tvalid),
        .i_pix       (i_s_tdata),
        .o_pix_ready (o_s_tready),
        .i_q_stat    (q_stat),
        .o_q_push    (q_push),
        .o_q_job     (q_in_job)
    );

    ckmc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    ckmc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (q_head),
        .i_q_stat   (q_stat),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // a centroid beat always closes the results of its pixel
    a_cent_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("centroid beat without tlast");

    // empty frame gives zero centroid and zero mask
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser && o_m_tdata[32]) |-> (o_m_tdata[31:0] == '0))
        else $error("empty frame with nonzero centroid");

    // mask beats carry only 0 or 255 and no centroid fields
    a_mask_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |->
            ((o_m_tdata[7:0] == MASK_ON || o_m_tdata[7:0] == MASK_OFF)
             && o_m_tdata[32:8] == '0))
        else $error("malformed mask beat");

endmodule

[sim/tb_color_key_mask_centroid.sv]
// Self-checking testbench for the color key mask and centroid block.
`timescale 1ns / 1ps

module tb_color_key_mask_centroid import ckmc_pkg::*;;

    localparam int HalfPeriod  = 4;
    localparam int PixelTarget = 1450;
    localparam int IdlePct     = 11;
    localparam int ReportCap   = 100;

    // indexes past the register file; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] mask;
        logic [POS_W-1:0] crow;
        logic [POS_W-1:0] ccol;
        logic             none;
        logic             last;
    } t_mask_beat;

    class t_mask_centroid_model;
        logic [PIX_W-1:0]  target [3];
        logic [THR_W-1:0]  threshold;
        logic [SIZE_W-1:0] rows_cfg;
        logic [SIZE_W-1:0] cols_cfg;
        logic [POS_W-1:0]  row_pos;
        logic [POS_W-1:0]  col_pos;
        logic [CNT_W-1:0]  marked;
        logic [SUM_W-1:0]  row_acc;
        logic [SUM_W-1:0]  col_acc;
        t_mask_beat        expected_beats [$];
        int errors, pixels, frames, empty_frames, reg_writes;

        function new();
            target[0] = RST_TARGET_CH0;
            target[1] = RST_TARGET_CH1;
            target[2] = RST_TARGET_CH2;
            threshold = RST_THRESHOLD;
            rows_cfg  = RST_ROWS;
            cols_cfg  = RST_COLS;
            row_pos = '0;
            col_pos = '0;
            marked  = '0;
            row_acc = '0;
            col_acc = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            reg_writes++;
            case (idx)
                CFG_TARGET_CH0: target[0] = val[PIX_W-1:0];
                CFG_TARGET_CH1: target[1] = val[PIX_W-1:0];
                CFG_TARGET_CH2: target[2] = val[PIX_W-1:0];
                CFG_THRESHOLD:  threshold = val[THR_W-1:0];
                CFG_ROWS:       rows_cfg  = val[SIZE_W-1:0];
                CFG_COLS:       cols_cfg  = val[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [S_DATA_W-1:0] d);
            int         nrows, ncols, l1_dist, diff;
            bit         hit, row_end, frame_end;
            t_mask_beat b;
            pixels++;
            nrows = (rows_cfg == 0) ? 1 : (rows_cfg > MaxRows) ? MaxRows : int'(rows_cfg);
            ncols = (cols_cfg == 0) ? 1 : (cols_cfg > MaxCols) ? MaxCols : int'(cols_cfg);
            l1_dist = 0;
            for (int i = 0; i < 3; i++) begin
                diff = int'(d[PIX_W*i +: PIX_W]) - int'(target[i]);
                l1_dist += (diff < 0) ? -diff : diff;
            end
            hit       = l1_dist >= int'(threshold);
            row_end   = int'(col_pos) + 1 >= ncols;
            frame_end = row_end && (int'(row_pos) + 1 >= nrows);
            if (hit) begin
                marked++;
                row_acc += SUM_W'(row_pos);
                col_acc += SUM_W'(col_pos);
            end
            b = '0;
            b.kind = KIND_MASK;
            b.mask = hit ? MASK_ON : MASK_OFF;
            b.last = !frame_end;
            expected_beats.push_back(b);
            if (!frame_end) begin
                if (row_end) begin
                    col_pos = '0;
                    row_pos++;
                end else begin
                    col_pos++;
                end
                return;
            end
            b = '0;
            b.kind = KIND_CENTROID;
            b.last = 1'b1;
            frames++;
            if (marked == 0) begin
                b.none = 1'b1;
                empty_frames++;
            end else begin
                b.crow = POS_W'(row_acc / marked);
                b.ccol = POS_W'(col_acc / marked);
            end
            expected_beats.push_back(b);
            row_pos = '0;
            col_pos = '0;
            marked  = '0;
            row_acc = '0;
            col_acc = '0;
        endfunction

        function void match(string field, logic [31:0] exp, logic [31:0] act);
            if (exp !== act) begin
                $error("%s: expected %0d, got %0d", field, exp, act);
                errors++;
            end
        endfunction

        function void check_beat(logic kind, logic [M_DATA_W-1:0] data, logic last);
            t_mask_beat e;
            if (expected_beats.size() == 0) begin
                if (errors < ReportCap)
                    $error("output beat with nothing pending: tuser=%b tdata=%h", kind, data);
                errors++;
                return;
            end
            e = expected_beats.pop_front();
            match("result_kind",  32'(e.kind), 32'(kind));
            match("mask_value",   32'(e.mask), 32'(data[7:0]));
            match("centroid_row", 32'(e.crow), 32'(data[19:8]));
            match("centroid_col", 32'(e.ccol), 32'(data[31:20]));
            match("no_pixels",    32'(e.none), 32'(data[32]));
            match("tdata_pad",    32'(0),      32'(data[M_DATA_W-1:33]));
            match("last_result",  32'(e.last), 32'(last));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic [S_DATA_W-1:0]   i_s_tdata = '0;
    logic                  i_m_tready = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [M_DATA_W-1:0]   o_m_tdata;
    logic                  o_m_tuser;
    logic                  o_m_tlast;

    bit                    no_gaps = 1'b0;
    t_mask_centroid_model  sb = new();

    color_key_mask_centroid u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always #(HalfPeriod) i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_m_tready <= no_gaps || ($urandom_range(99) >= IdlePct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_beat(o_m_tuser, o_m_tdata, o_m_tlast);
    end

    // leaves valid high so back-to-back writes follow each other without a gap
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] c0, c1, c2);
        while (!no_gaps && $urandom_range(99) < IdlePct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {c2, c1, c0};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_pixel({c2, c1, c0});
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] near(input logic [PIX_W-1:0] t);
        int v;
        v = int'(t) + int'($urandom_range(80)) - 40;
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : PIX_W'(v);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size(input int typical);
        int r;
        r = $urandom_range(99);
        if (r < 5)  return '0;
        if (r < 10) return CFG_DATA_W'($urandom_range(8191, MaxRows));
        return CFG_DATA_W'($urandom_range(typical, 1));
    endfunction

    initial begin
        int phase, n, r, thr;
        logic [PIX_W-1:0] c [3];

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // default colors and threshold, one row of four: near hit, far corners, edge
        write_reg(CFG_ROWS, 13'd1);
        write_reg(CFG_COLS, 13'd4);
        i_cfg_valid <= 1'b0;
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd200, 8'd0, 8'd0);
        wait_drained();

        // threshold past any distance: empty frame; zero columns act as one
        write_reg(CFG_THRESHOLD, 13'd1023);
        write_reg(CFG_COLS, 13'd0);
        write_reg(CFG_ROWS, 13'd2);
        i_cfg_valid <= 1'b0;
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        wait_drained();

        // zero threshold marks everything; wide data and spare indexes
        write_reg(CFG_THRESHOLD, 13'd0);
        write_reg(CFG_TARGET_CH0, 13'h1F00);
        write_reg(CFG_TARGET_CH1, 13'h1FFF);
        write_reg(CFG_TARGET_CH2, 13'd170);
        write_reg(CFG_SPARE_6, 13'd1);
        write_reg(CFG_SPARE_7, 13'h1FFF);
        write_reg(CFG_ROWS, 13'd3);
        write_reg(CFG_COLS, 13'd3);
        i_cfg_valid <= 1'b0;
        for (int i = 0; i < 9; i++)
            send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
        wait_drained();

        // oversized frame, then shrunk below the current row mid-frame
        write_reg(CFG_THRESHOLD, 13'd200);
        write_reg(CFG_ROWS, 13'h1FFF);
        write_reg(CFG_COLS, 13'd2);
        i_cfg_valid <= 1'b0;
        for (int i = 0; i < 6; i++)
            send_pixel(PIX_W'($urandom), 8'd0, PIX_W'($urandom));
        wait_drained();
        write_reg(CFG_ROWS, 13'd2);
        i_cfg_valid <= 1'b0;
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd17, 8'd99, 8'd3);
        wait_drained();

        phase = 0;
        while (sb.pixels < PixelTarget) begin
            no_gaps = (phase >= 20 && phase < 26);
            r = $urandom_range(99);
            thr = (r < 8) ? 0 : (r < 16) ? $urandom_range(1023, 766) : $urandom_range(350);
            if ($urandom_range(4) == 0)
                write_reg(($urandom_range(1) != 0) ? CFG_SPARE_6 : CFG_SPARE_7,
                          CFG_DATA_W'($urandom));
            write_reg(CFG_TARGET_CH0, CFG_DATA_W'($urandom));
            write_reg(CFG_TARGET_CH1, CFG_DATA_W'($urandom));
            write_reg(CFG_TARGET_CH2, CFG_DATA_W'($urandom));
            write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
            write_reg(CFG_ROWS, pick_size(6));
            write_reg(CFG_COLS, pick_size(9));
            i_cfg_valid <= 1'b0;
            n = $urandom_range(48, 4);
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(99);
                for (int k = 0; k < 3; k++) begin
                    if (r < 50)
                        c[k] = near(sb.target[k]);
                    else if (r < 90)
                        c[k] = PIX_W'($urandom);
                    else
                        c[k] = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
                end
                send_pixel(c[0], c[1], c[2]);
            end
            wait_drained();
            phase++;
        end
        no_gaps = 1'b0;

        // anything stray shows up well inside this wait
        repeat (40) @(negedge i_clk);

        $display("Covered %0d pixels in %0d frames (%0d with no marked pixel), %0d phases,",
                 sb.pixels, sb.frames, sb.empty_frames, phase + 5);
        $display("%0d register writes including dropped indexes; %0d mismatches.",
                 sb.reg_writes, sb.errors);
        if (sb.errors == 0 && sb.expected_beats.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d beats still pending", sb.expected_beats.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
